FILE: src/php_pkg.sv
// package for the delta-patch header parser
// shared payload structs, result kinds and size constants; no dependencies
package php_pkg;

  localparam int unsigned ChunkBytesDefault = 32768;
  localparam int unsigned FifoDepth = 2;
  localparam logic [31:0] Signature = 32'h3931_4150;
  localparam logic [31:0] ReqFlags = 32'h0044_0001;
  localparam logic [31:0] OptFlags = 32'hC080_0004;
  localparam logic [31:0] FlNoTime = 32'h0080_0000;
  localparam logic [31:0] FlInterleave = 32'h4000_0000;
  localparam logic [31:0] FlExtended = 32'h8000_0000;
  localparam logic [31:0] FlWindow = 32'h0001_0000;
  localparam logic [31:0] MinLength = 32'd28;
  localparam logic [16:0] MaxCapacity = 17'd65536;
  localparam logic [16:0] CapacityReset = 17'd16;

  typedef enum logic [2:0] {
    KIND_NEW_SIZE  = 3'd0,
    KIND_WINDOW    = 3'd1,
    KIND_OLD_SIZE  = 3'd2,
    KIND_COUNT     = 3'd3,
    KIND_ENTRY     = 3'd4,
    KIND_DONE      = 3'd5,
    KIND_INVALID   = 3'd6,
    KIND_NO_ROOM   = 3'd7
  } kind_e;

  typedef struct packed {
    logic        start_req;
    logic [7:0]  data_byte;
    logic [31:0] buffer_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [15:0] entry_index;
    logic [31:0] old_offset;
    logic [31:0] old_length;
    logic [31:0] new_length;
    logic [31:0] header_bytes;
    logic        last;
  } out_item_t;

endpackage

FILE: src/php_fifo.sv
// small result queue between the parser and the result port
// depends on php_pkg for the result struct
module php_fifo #(
  parameter int unsigned Depth = php_pkg::FifoDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  php_pkg::out_item_t  data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output php_pkg::out_item_t  data_o
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  php_pkg::out_item_t mem_q [Depth];
  logic [Aw-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [Aw:0]   cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (Aw+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (do_push) begin
      wr_d = (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d = cnt_q + (Aw+1)'(do_push) - (Aw+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule

FILE: src/php_parser.sv
// byte-serial header parser: field walk, varint decode, entry rebuild
// depends on php_pkg for payload structs and constants
module php_parser #(
  parameter int unsigned ChunkBytes = php_pkg::ChunkBytesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  php_pkg::in_item_t   item_i,
  input  logic [16:0]         capacity_i,
  output logic                res_valid_o,
  output php_pkg::out_item_t  res_o
);
  typedef enum logic [4:0] {
    P_IDLE, P_SIG, P_FLAGS, P_EXT, P_TIME, P_NEWSIZE, P_CRC1, P_WINDOW,
    P_COUNT, P_OLDDELTA, P_CRC2, P_RANGES, P_RIFT, P_ECOUNT, P_EOFF,
    P_ELEN, P_ENEW, P_PDS, P_DONE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  bif_q, bif_d;
  logic [31:0] fval_q, fval_d;
  logic [5:0]  fsh_q, fsh_d;
  logic        fneg_q, fneg_d;
  logic [3:0]  marks_q, marks_d;
  logic [31:0] left_q, left_d, used_q, used_d;
  logic [31:0] new_size_q, new_size_d, old_size_q, old_size_d;
  logic [31:0] total_q, total_d, ecnt_q, ecnt_d;
  logic [31:0] off_q, off_d, len_q, len_d, nlen_q, nlen_d;
  logic [31:0] doff_q, doff_d, dlen_q, dlen_d, rem_q, rem_d;
  logic        vld_d;
  php_pkg::out_item_t res_d;

  logic [7:0]  b;
  logic [31:0] fix_v, uns_v, sgn_v, sw;
  logic [31:0] fv_c;
  logic [2:0]  bif_c;
  logic [2:0]  fix_n;
  logic [5:0]  uns_sh, sgn_sh;
  logic        uns_done, sgn_done, sgn_neg;
  logic [32:0] sum33, ext33;
  logic [31:0] flags_x;

  assign b = item_i.data_byte;

  always_comb begin
    // a start beat begins with a clean field
    fv_c   = item_i.start_req ? '0 : fval_q;
    bif_c  = item_i.start_req ? '0 : bif_q;
    fix_v  = fv_c | (32'(b) << {bif_c[1:0], 3'b000});
    fix_n  = bif_c + 3'd1;
    uns_v  = fval_q | (32'(b[6:0]) << fsh_q[4:0]);
    uns_sh = fsh_q + 6'd7;
    uns_done = b[7] || (uns_sh >= 6'd32);
    if (bif_q == '0) begin
      sgn_v    = 32'(b[5:0]);
      sgn_neg  = b[6];
      sgn_sh   = 6'd6;
      sgn_done = b[7];
    end else begin
      sgn_v    = uns_v;
      sgn_neg  = fneg_q;
      sgn_sh   = uns_sh;
      sgn_done = uns_done;
    end
    sw = sgn_neg ? (32'd0 - sgn_v) : sgn_v;
  end

  function automatic php_pkg::out_item_t mk(php_pkg::kind_e k, logic [31:0] v,
                                            logic l);
    php_pkg::out_item_t r;
    r = '0;
    r.kind = k;
    r.value = v;
    r.last = l;
    return r;
  endfunction

  always_comb begin
    phase_d = phase_q; bif_d = bif_q; fval_d = fval_q; fsh_d = fsh_q;
    fneg_d = fneg_q; marks_d = marks_q; left_d = left_q; used_d = used_q;
    new_size_d = new_size_q; old_size_d = old_size_q; total_d = total_q;
    ecnt_d = ecnt_q; off_d = off_q; len_d = len_q; nlen_d = nlen_q;
    doff_d = doff_q; dlen_d = dlen_q; rem_d = rem_q;
    vld_d = 1'b0;
    res_d = '0;
    sum33 = '0; ext33 = '0; flags_x = '0;

    if (valid_i) begin
      logic run;
      logic [31:0] budget;
      phase_e ph;
      logic [31:0] ub;
      ph = phase_q;
      budget = left_q;
      run = 1'b1;
      ub = used_q;
      if (item_i.start_req) begin
        bif_d = '0; fval_d = '0; fsh_d = '0; fneg_d = '0; marks_d = '0;
        new_size_d = '0; old_size_d = '0; total_d = '0; ecnt_d = '0;
        off_d = '0; len_d = '0; nlen_d = '0; doff_d = '0; dlen_d = '0; rem_d = '0;
        budget = item_i.buffer_length;
        ub = '0;
        left_d = budget;
        used_d = '0;
        ph = P_SIG;
        phase_d = P_SIG;
        if (budget < php_pkg::MinLength) begin
          run = 1'b0; phase_d = P_DONE; vld_d = 1'b1;
          res_d = mk(php_pkg::KIND_INVALID, '0, 1'b1);
        end else if (capacity_i == '0) begin
          run = 1'b0; phase_d = P_DONE; vld_d = 1'b1;
          res_d = mk(php_pkg::KIND_NO_ROOM, '0, 1'b1);
        end
      end else if (phase_q == P_IDLE || phase_q == P_DONE) begin
        run = 1'b0;
      end

      if (run && budget == '0) begin
        run = 1'b0; phase_d = P_DONE; vld_d = 1'b1;
        res_d = mk(php_pkg::KIND_INVALID, '0, 1'b1);
      end

      if (run) begin
        left_d = budget - 32'd1;
        used_d = ub + 32'd1;
        case (ph)
          P_SIG, P_FLAGS, P_EXT, P_TIME, P_CRC1, P_CRC2, P_RANGES: begin
            fval_d = fix_v;
            bif_d  = fix_n;
            if ((ph == P_RANGES) ? (fix_n >= 3'd2) : (fix_n >= 3'd4)) begin
              bif_d = '0; fval_d = '0; fsh_d = '0; fneg_d = '0;
              case (ph)
                P_SIG: begin
                  if (fix_v != php_pkg::Signature) begin
                    phase_d = P_DONE; vld_d = 1'b1;
                    res_d = mk(php_pkg::KIND_INVALID, '0, 1'b1);
                  end else begin
                    phase_d = P_FLAGS;
                  end
                end
                P_FLAGS: begin
                  if ((fix_v & php_pkg::ReqFlags) != php_pkg::ReqFlags ||
                      (fix_v & ~(php_pkg::ReqFlags | php_pkg::OptFlags)) != '0) begin
                    phase_d = P_DONE; vld_d = 1'b1;
                    res_d = mk(php_pkg::KIND_INVALID, '0, 1'b1);
                  end else begin
                    flags_x = fix_v ^ php_pkg::FlNoTime;
                    marks_d = {(flags_x & php_pkg::FlInterleave) != '0, 1'b0,
                               (flags_x & php_pkg::FlNoTime) == '0,
                               (flags_x & php_pkg::FlExtended) != '0};
                    phase_d = marks_d[0] ? P_EXT : (marks_d[1] ? P_TIME : P_NEWSIZE);
                  end
                end
                P_EXT: begin
                  marks_d[2] = (fix_v & php_pkg::FlWindow) != '0;
                  phase_d = marks_q[1] ? P_TIME : P_NEWSIZE;
                end
                P_TIME:   phase_d = P_NEWSIZE;
                P_CRC1:   phase_d = marks_q[2] ? P_WINDOW : P_COUNT;
                P_CRC2:   phase_d = P_RANGES;
                P_RANGES: begin
                  if (fix_v != '0) begin
                    phase_d = P_DONE; vld_d = 1'b1;
                    res_d = mk(php_pkg::KIND_INVALID, '0, 1'b1);
                  end else begin
                    phase_d = P_RIFT;
                  end
                end
                default: phase_d = P_DONE;
              endcase
            end
          end
          P_NEWSIZE, P_RIFT, P_ECOUNT, P_PDS: begin
            fval_d = uns_v;
            fsh_d  = uns_sh;
            if (uns_done) begin
              bif_d = '0; fval_d = '0; fsh_d = '0; fneg_d = '0;
              case (ph)
                P_NEWSIZE: begin
                  new_size_d = uns_v; rem_d = uns_v; phase_d = P_CRC1; vld_d = 1'b1;
                  res_d = mk(php_pkg::KIND_NEW_SIZE, uns_v, 1'b0);
                end
                P_RIFT: begin
                  if (uns_v != '0) begin
                    phase_d = P_DONE; vld_d = 1'b1;
                    res_d = mk(php_pkg::KIND_INVALID, '0, 1'b1);
                  end else if (marks_q[3]) begin
                    phase_d = P_ECOUNT;
                  end else begin
                    total_d = 32'd1; ecnt_d = 32'd1; off_d = '0; len_d = old_size_q;
                    phase_d = P_PDS; vld_d = 1'b1;
                    res_d = mk(php_pkg::KIND_ENTRY, '0, 1'b0);
                    res_d.old_length = old_size_q;
                    res_d.new_length = rem_q;
                  end
                end
                P_ECOUNT: begin
                  if (uns_v == '0) begin
                    phase_d = P_DONE; vld_d = 1'b1;
                    res_d = mk(php_pkg::KIND_INVALID, '0, 1'b1);
                  end else if (uns_v > 32'(capacity_i)) begin
                    phase_d = P_DONE; vld_d = 1'b1;
                    res_d = mk(php_pkg::KIND_NO_ROOM, '0, 1'b1);
                  end else begin
                    total_d = uns_v; ecnt_d = '0; phase_d = P_EOFF; vld_d = 1'b1;
                    res_d = mk(php_pkg::KIND_COUNT, uns_v, 1'b0);
                  end
                end
                default: begin
                  phase_d = P_DONE; vld_d = 1'b1;
                  res_d = mk(php_pkg::KIND_DONE, uns_v, 1'b1);
                  res_d.header_bytes = ub + 32'd1;
                end
              endcase
            end
          end
          P_WINDOW: begin
            phase_d = P_COUNT; vld_d = 1'b1;
            res_d = mk(php_pkg::KIND_WINDOW, 32'(b), 1'b0);
          end
          P_COUNT: begin
            if (b != 8'd1) begin
              phase_d = P_DONE; vld_d = 1'b1;
              res_d = mk(php_pkg::KIND_INVALID, '0, 1'b1);
            end else begin
              phase_d = P_OLDDELTA;
            end
          end
          P_OLDDELTA, P_EOFF, P_ELEN, P_ENEW: begin
            bif_d = 3'd1; fval_d = sgn_v; fsh_d = sgn_sh; fneg_d = sgn_neg;
            if (sgn_done) begin
              bif_d = '0; fval_d = '0; fsh_d = '0; fneg_d = '0;
              case (ph)
                P_OLDDELTA: begin
                  if (sgn_neg) sum33 = {1'b0, new_size_q} - {1'b0, sgn_v};
                  else         sum33 = {1'b0, new_size_q} + {1'b0, sgn_v};
                  if (sum33[32]) begin
                    phase_d = P_DONE; vld_d = 1'b1;
                    res_d = mk(php_pkg::KIND_INVALID, '0, 1'b1);
                  end else begin
                    old_size_d = sum33[31:0]; phase_d = P_CRC2; vld_d = 1'b1;
                    res_d = mk(php_pkg::KIND_OLD_SIZE, sum33[31:0], 1'b0);
                  end
                end
                P_EOFF: begin
                  doff_d = doff_q + sw;
                  off_d = off_q + doff_q + sw;
                  phase_d = P_ELEN;
                end
                P_ELEN: begin
                  dlen_d = dlen_q + sw;
                  len_d = len_q + dlen_q + sw;
                  ext33 = {1'b0, off_q} + {1'b0, len_d};
                  if (ext33 > {1'b0, old_size_q}) begin
                    phase_d = P_DONE; vld_d = 1'b1;
                    res_d = mk(php_pkg::KIND_INVALID, '0, 1'b1);
                  end else if (ecnt_q + 32'd1 >= total_q) begin
                    ecnt_d = ecnt_q + 32'd1;
                    phase_d = (ecnt_d >= total_q) ? P_PDS : P_EOFF;
                    vld_d = 1'b1;
                    res_d = mk(php_pkg::KIND_ENTRY, '0, 1'b0);
                    res_d.entry_index = ecnt_q[15:0];
                    res_d.old_offset = off_q;
                    res_d.old_length = len_d;
                    res_d.new_length = rem_q;
                  end else begin
                    phase_d = P_ENEW;
                  end
                end
                default: begin
                  nlen_d = nlen_q + 32'(64'(sw) * 64'(ChunkBytes));
                  if (rem_q < nlen_d) begin
                    phase_d = P_DONE; vld_d = 1'b1;
                    res_d = mk(php_pkg::KIND_INVALID, '0, 1'b1);
                  end else begin
                    rem_d = rem_q - nlen_d;
                    ecnt_d = ecnt_q + 32'd1;
                    phase_d = (ecnt_d >= total_q) ? P_PDS : P_EOFF;
                    vld_d = 1'b1;
                    res_d = mk(php_pkg::KIND_ENTRY, '0, 1'b0);
                    res_d.entry_index = ecnt_q[15:0];
                    res_d.old_offset = off_q;
                    res_d.old_length = len_q;
                    res_d.new_length = nlen_d;
                  end
                end
              endcase
            end
          end
          default: phase_d = P_DONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE; bif_q <= '0; fval_q <= '0; fsh_q <= '0; fneg_q <= 1'b0;
      marks_q <= '0; left_q <= '0; used_q <= '0; new_size_q <= '0;
      old_size_q <= '0; total_q <= '0; ecnt_q <= '0; off_q <= '0; len_q <= '0;
      nlen_q <= '0; doff_q <= '0; dlen_q <= '0; rem_q <= '0;
      res_valid_o <= 1'b0; res_o <= '0;
    end else begin
      phase_q <= phase_d; bif_q <= bif_d; fval_q <= fval_d; fsh_q <= fsh_d;
      fneg_q <= fneg_d; marks_q <= marks_d; left_q <= left_d; used_q <= used_d;
      new_size_q <= new_size_d; old_size_q <= old_size_d; total_q <= total_d;
      ecnt_q <= ecnt_d; off_q <= off_d; len_q <= len_d; nlen_q <= nlen_d;
      doff_q <= doff_d; dlen_q <= dlen_d; rem_q <= rem_d;
      res_valid_o <= vld_d; res_o <= res_d;
    end
  end
endmodule

FILE: src/patch_header_parser.sv
// top level of the delta-patch header parser
// depends on php_pkg, php_parser and php_fifo
// One header byte is taken per clock cycle while full is low, back to back; each
// byte yields at most one registered result, pushed into a two-entry result queue. The input
// shows full when the queued results plus the one in flight, less one being
// popped, would fill the queue, so a byte is never lost; with pop held high the
// block sustains one byte per cycle, as the varint and entry step is combinational on each byte.
module patch_header_parser #(
  parameter int unsigned ChunkBytes = php_pkg::ChunkBytesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  php_pkg::in_item_t   in_item_i,
  output logic                empty,
  input  logic                pop,
  output php_pkg::out_item_t  out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [16:0]         cfg_data_i
);
  logic [16:0] cap_q;
  logic        res_valid, q_full, take;
  php_pkg::out_item_t res;
  logic [1:0]  occ;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= php_pkg::CapacityReset;
    end else if (cfg_valid_i) begin
      cap_q <= (cfg_data_i > php_pkg::MaxCapacity) ? php_pkg::MaxCapacity : cfg_data_i;
    end
  end

  // occupancy of the queued and in-flight results, less one being popped
  assign occ  = {q_full, !empty && !q_full} + 2'(res_valid) - 2'(pop && !empty);
  assign full = (occ >= 2'd2);
  assign take = push && !full;

  php_parser #(.ChunkBytes(ChunkBytes)) u_parser (
    .clk_i, .rst_ni,
    .valid_i     (take),
    .item_i      (in_item_i),
    .capacity_i  (cap_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  php_fifo #(.Depth(php_pkg::FifoDepth)) u_fifo (
    .clk_i, .rst_ni,
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (out_item_o)
  );
endmodule

FILE: verif/testbench.sv
// self-checking bench for patch_header_parser: byte-serial header stimulus,
// in-bench parse predictor and in-order result checks on the result queue
// depends on php_pkg and the patch_header_parser rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Chunk = php_pkg::ChunkBytesDefault;
  localparam int unsigned StallLimit = 20000;

  typedef enum logic [4:0] {
    PH_IDLE, PH_SIG, PH_FLAGS, PH_EXT, PH_TIME, PH_NEWSIZE, PH_CRC1, PH_WINDOW,
    PH_COUNT, PH_OLDDELTA, PH_CRC2, PH_RANGES, PH_RIFT, PH_ECOUNT, PH_EOFF,
    PH_ELEN, PH_ENEW, PH_PDS, PH_DONE
  } parse_ph_e;

  typedef struct {
    php_pkg::in_item_t it;
    bit                chk;
    php_pkg::kind_e    kind;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  php_pkg::in_item_t in_item_i = '0;
  logic empty;
  logic pop = 1'b0;
  php_pkg::out_item_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [16:0] cfg_data_i = '0;
  bit tag_chk = 1'b0;
  php_pkg::kind_e tag_kind = php_pkg::KIND_NEW_SIZE;

  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  php_pkg::out_item_t results_due[$];
  logic [7:0] hdr_q[$];
  dir_row_t dir_rows[$];

  // predictor state
  logic [16:0] cap_q = php_pkg::CapacityReset;
  parse_ph_e ph = PH_IDLE;
  logic [2:0] bif;
  logic [31:0] fv;
  logic [5:0] fsh;
  logic fneg;
  logic [3:0] marks;
  logic [31:0] bleft, bused, nsz, osz, etot, ecnt;
  logic [31:0] rs[7];

  patch_header_parser uut (
    .clk_i, .rst_ni, .push, .full, .in_item_i, .empty, .pop, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  function automatic php_pkg::out_item_t mk(logic [2:0] k, logic [31:0] v,
                                            logic [15:0] idx, logic [31:0] off,
                                            logic [31:0] len, logic [31:0] nlen,
                                            logic [31:0] hb, logic lst);
    php_pkg::out_item_t r;
    r.kind = k; r.value = v; r.entry_index = idx; r.old_offset = off;
    r.old_length = len; r.new_length = nlen; r.header_bytes = hb; r.last = lst;
    return r;
  endfunction

  function automatic php_pkg::out_item_t abort_parse(php_pkg::kind_e k);
    ph = PH_DONE;
    return mk(k, 0, 0, 0, 0, 0, 0, 1'b1);
  endfunction

  function automatic void next_field(parse_ph_e p);
    ph = p; bif = 0; fv = 0; fsh = 0; fneg = 0;
  endfunction

  function automatic bit take_fixed(logic [7:0] b, int n);
    fv |= {24'b0, b} << (bif[1:0] * 8);
    bif = bif + 3'd1;
    return bif >= n;
  endfunction

  function automatic bit take_uvar(logic [7:0] b);
    fv |= {25'b0, b[6:0]} << fsh[4:0];
    fsh = fsh + 6'd7;
    return b[7] || fsh >= 32;
  endfunction

  function automatic bit take_svar(logic [7:0] b);
    if (bif == 0) begin
      bif = 1; fv = {26'b0, b[5:0]}; fneg = b[6]; fsh = 6;
      return b[7];
    end
    return take_uvar(b);
  endfunction

  function automatic logic [31:0] svar_val();
    return fneg ? 32'd0 - fv : fv;
  endfunction

  function automatic php_pkg::out_item_t entry_beat(logic [31:0] nlen);
    logic [31:0] idx;
    idx = ecnt;
    ecnt = ecnt + 1;
    next_field(ecnt >= etot ? PH_PDS : PH_EOFF);
    return mk(php_pkg::KIND_ENTRY, 0, idx[15:0], rs[0], rs[1], nlen, 0, 1'b0);
  endfunction

  function automatic bit parse_byte(php_pkg::in_item_t it, output php_pkg::out_item_t r);
    logic [7:0] b;
    logic [31:0] f, d;
    longint s, sum;
    b = it.data_byte;
    r = '0;
    if (it.start_req) begin
      marks = 0; bused = 0; nsz = 0; osz = 0; etot = 0; ecnt = 0;
      for (int i = 0; i < 7; i++) rs[i] = 0;
      next_field(PH_IDLE);
      bleft = it.buffer_length;
      if (bleft < php_pkg::MinLength) begin
        r = abort_parse(php_pkg::KIND_INVALID); return 1;
      end
      if (cap_q == 0) begin r = abort_parse(php_pkg::KIND_NO_ROOM); return 1; end
      next_field(PH_SIG);
    end else if (ph == PH_IDLE || ph >= PH_DONE) begin
      return 0;
    end
    if (bleft == 0) begin r = abort_parse(php_pkg::KIND_INVALID); return 1; end
    bleft = bleft - 1;
    bused = bused + 1;
    case (ph)
      PH_SIG: if (take_fixed(b, 4)) begin
        if (fv != php_pkg::Signature) begin
          r = abort_parse(php_pkg::KIND_INVALID); return 1;
        end
        next_field(PH_FLAGS);
      end
      PH_FLAGS: if (take_fixed(b, 4)) begin
        f = fv;
        if ((f & php_pkg::ReqFlags) != php_pkg::ReqFlags ||
            (f & ~(php_pkg::ReqFlags | php_pkg::OptFlags)) != 0) begin
          r = abort_parse(php_pkg::KIND_INVALID); return 1;
        end
        f ^= php_pkg::FlNoTime;
        marks = 0;
        if (f & php_pkg::FlExtended) marks[0] = 1;
        if ((f & php_pkg::FlNoTime) == 0) marks[1] = 1;
        if (f & php_pkg::FlInterleave) marks[3] = 1;
        next_field(marks[0] ? PH_EXT : marks[1] ? PH_TIME : PH_NEWSIZE);
      end
      PH_EXT: if (take_fixed(b, 4)) begin
        if (fv & php_pkg::FlWindow) marks[2] = 1;
        next_field(marks[1] ? PH_TIME : PH_NEWSIZE);
      end
      PH_TIME: if (take_fixed(b, 4)) next_field(PH_NEWSIZE);
      PH_NEWSIZE: if (take_uvar(b)) begin
        nsz = fv; rs[5] = fv;
        next_field(PH_CRC1);
        r = mk(php_pkg::KIND_NEW_SIZE, nsz, 0, 0, 0, 0, 0, 1'b0); return 1;
      end
      PH_CRC1: if (take_fixed(b, 4)) next_field(marks[2] ? PH_WINDOW : PH_COUNT);
      PH_WINDOW: begin
        next_field(PH_COUNT);
        r = mk(php_pkg::KIND_WINDOW, {24'b0, b}, 0, 0, 0, 0, 0, 1'b0); return 1;
      end
      PH_COUNT: begin
        if (b != 1) begin r = abort_parse(php_pkg::KIND_INVALID); return 1; end
        next_field(PH_OLDDELTA);
      end
      PH_OLDDELTA: if (take_svar(b)) begin
        s = fneg ? -longint'({32'b0, fv}) : longint'({32'b0, fv});
        sum = s + longint'({32'b0, nsz});
        if (sum < 0 || sum > 64'hFFFF_FFFF) begin
          r = abort_parse(php_pkg::KIND_INVALID); return 1;
        end
        osz = sum[31:0];
        next_field(PH_CRC2);
        r = mk(php_pkg::KIND_OLD_SIZE, osz, 0, 0, 0, 0, 0, 1'b0); return 1;
      end
      PH_CRC2: if (take_fixed(b, 4)) next_field(PH_RANGES);
      PH_RANGES: if (take_fixed(b, 2)) begin
        if (fv != 0) begin r = abort_parse(php_pkg::KIND_INVALID); return 1; end
        next_field(PH_RIFT);
      end
      PH_RIFT: if (take_uvar(b)) begin
        if (fv != 0) begin r = abort_parse(php_pkg::KIND_INVALID); return 1; end
        if (marks[3]) begin next_field(PH_ECOUNT); return 0; end
        etot = 1; ecnt = 0; rs[0] = 0; rs[1] = osz;
        r = entry_beat(rs[5]); return 1;
      end
      PH_ECOUNT: if (take_uvar(b)) begin
        if (fv == 0) begin r = abort_parse(php_pkg::KIND_INVALID); return 1; end
        if (fv > {15'b0, cap_q}) begin
          r = abort_parse(php_pkg::KIND_NO_ROOM); return 1;
        end
        etot = fv; ecnt = 0;
        next_field(PH_EOFF);
        r = mk(php_pkg::KIND_COUNT, etot, 0, 0, 0, 0, 0, 1'b0); return 1;
      end
      PH_EOFF: if (take_svar(b)) begin
        rs[3] = rs[3] + svar_val();
        rs[0] = rs[0] + rs[3];
        next_field(PH_ELEN);
      end
      PH_ELEN: if (take_svar(b)) begin
        rs[4] = rs[4] + svar_val();
        rs[1] = rs[1] + rs[4];
        if ({1'b0, rs[0]} + {1'b0, rs[1]} > {1'b0, osz}) begin
          r = abort_parse(php_pkg::KIND_INVALID); return 1;
        end
        if (ecnt + 1 >= etot) begin r = entry_beat(rs[5]); return 1; end
        next_field(PH_ENEW);
      end
      PH_ENEW: if (take_svar(b)) begin
        d = svar_val() * Chunk;
        rs[2] = rs[2] + d;
        if (rs[5] < rs[2]) begin r = abort_parse(php_pkg::KIND_INVALID); return 1; end
        rs[5] = rs[5] - rs[2];
        r = entry_beat(rs[2]); return 1;
      end
      PH_PDS: if (take_uvar(b)) begin
        ph = PH_DONE;
        r = mk(php_pkg::KIND_DONE, fv, 0, 0, 0, 0, bused, 1'b1); return 1;
      end
      default: ;
    endcase
    return 0;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    php_pkg::out_item_t r, w;
    bit got, act;
    if (rst_ni) begin
      act = 1'b0;
      if (!empty && pop) begin
        act = 1'b1;
        r = out_item_o;
        if (results_due.size() == 0) begin
          report_mismatch("unexpected beat kind", r.kind, 0);
        end else begin
          w = results_due.pop_front();
          if (r.kind != w.kind) report_mismatch("kind", r.kind, w.kind);
          if (r.value != w.value) report_mismatch("value", r.value, w.value);
          if (r.entry_index != w.entry_index)
            report_mismatch("entry_index", r.entry_index, w.entry_index);
          if (r.old_offset != w.old_offset)
            report_mismatch("old_offset", r.old_offset, w.old_offset);
          if (r.old_length != w.old_length)
            report_mismatch("old_length", r.old_length, w.old_length);
          if (r.new_length != w.new_length)
            report_mismatch("new_length", r.new_length, w.new_length);
          if (r.header_bytes != w.header_bytes)
            report_mismatch("header_bytes", r.header_bytes, w.header_bytes);
          if (r.last != w.last) report_mismatch("last", r.last, w.last);
        end
      end
      if (push && !full) begin
        act = 1'b1;
        got = parse_byte(in_item_i, w);
        if (got) results_due.push_back(w);
        if (tag_chk && (!got || w.kind != tag_kind))
          report_mismatch("directed kind", got ? w.kind : 32'hFFFF_FFFF, tag_kind);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        act = 1'b1;
        cap_q = cfg_data_i > php_pkg::MaxCapacity ? php_pkg::MaxCapacity : cfg_data_i;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      quiet_cycles <= act ? 0 : quiet_cycles + 1;
    end
  end

  always @(posedge clk_i) pop <= ($urandom_range(99) >= recv_stall_pct);

  task automatic send_byte(php_pkg::in_item_t it, bit chk = 0,
                           php_pkg::kind_e k = php_pkg::KIND_NEW_SIZE);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= it;
    tag_chk <= chk;
    tag_kind <= k;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic drain(int unsigned extra);
    push <= 1'b0;
    tag_chk <= 1'b0;
    @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [16:0] v);
    drain(8);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void add_row(bit st, logic [7:0] b, logic [31:0] len,
                                  bit chk = 0, php_pkg::kind_e k = php_pkg::KIND_NEW_SIZE);
    dir_row_t row;
    row.it = '{start_req: st, data_byte: b, buffer_length: len};
    row.chk = chk;
    row.kind = k;
    dir_rows.push_back(row);
  endfunction

  function automatic void put_fixed(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) hdr_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_uvar(logic [31:0] v);
    for (int i = 0; i < 5; i++) begin
      if ((v >> 7) == 0) begin hdr_q.push_back({1'b1, v[6:0]}); return; end
      hdr_q.push_back({1'b0, v[6:0]});
      v = v >> 7;
    end
  endfunction

  function automatic void put_smag(bit neg, logic [31:0] mag);
    logic [31:0] rest;
    rest = mag >> 6;
    hdr_q.push_back({rest == 0, neg, mag[5:0]});
    if (rest != 0) put_uvar(rest);
  endfunction

  function automatic void put_swrap(logic [31:0] e);
    put_smag(e[31], e[31] ? 32'd0 - e : e);
  endfunction

  // random header, mostly well-formed, sometimes broken afterwards
  function automatic void build_header();
    logic [31:0] flags, new_sz, old_sz, off, len, poff, plen, pd3, pd4, d3, d4;
    int unsigned n, k, pk, lim;
    bit ilv;
    hdr_q.delete();
    put_fixed(php_pkg::Signature, 4);
    flags = php_pkg::ReqFlags | ($urandom & php_pkg::OptFlags);
    ilv = flags[30];
    put_fixed(flags, 4);
    if (flags[31]) put_fixed($urandom, 4);
    // timestamp follows when this flag bit is set
    if (flags[23]) put_fixed($urandom, 4);
    new_sz = $urandom_range(2) == 0 ? $urandom_range(300) : $urandom;
    put_uvar(new_sz);
    put_fixed($urandom, 4);
    if (flags[31] && hdr_q[10][0]) hdr_q.push_back(8'($urandom));
    hdr_q.push_back(8'd1);
    old_sz = $urandom_range(3) == 0 ? $urandom_range(5000) : $urandom;
    if (old_sz >= new_sz) put_smag(0, old_sz - new_sz);
    else put_smag(1, new_sz - old_sz);
    put_fixed($urandom, 4);
    put_fixed(0, 2);
    hdr_q.push_back(8'h80);
    if (ilv) begin
      lim = cap_q > 5 ? 5 : cap_q;
      n = lim == 0 ? 1 : $urandom_range(lim, 1);
      if ($urandom_range(15) == 0) n = $urandom_range(1) ? 0 : cap_q + 1;
      put_uvar(n);
      poff = 0; plen = 0; pd3 = 0; pd4 = 0; pk = 0;
      for (int unsigned i = 0; i < n && i < 6; i++) begin
        off = $urandom_range(old_sz / 2);
        len = $urandom_range(old_sz - off);
        d3 = off - poff; d4 = len - plen;
        put_swrap(d3 - pd3);
        put_swrap(d4 - pd4);
        poff = off; plen = len; pd3 = d3; pd4 = d4;
        if (i + 1 < n) begin
          k = $urandom_range(3);
          put_swrap(k - pk);
          pk = k;
        end
      end
    end
    put_uvar($urandom);
    if ($urandom_range(5) == 0) hdr_q[$urandom_range(hdr_q.size() - 1)] = 8'($urandom);
  endfunction

  task automatic send_header();
    logic [31:0] blen;
    php_pkg::in_item_t it;
    build_header();
    case ($urandom_range(5))
      0: blen = hdr_q.size() > 2 ? hdr_q.size() - $urandom_range(2, 1) : 28;
      1: blen = $urandom;
      default: blen = hdr_q.size() < 28 ? 28 : hdr_q.size();
    endcase
    for (int i = 0; i < hdr_q.size(); i++) begin
      it.start_req = (i == 0);
      it.data_byte = hdr_q[i];
      it.buffer_length = i == 0 ? blen : $urandom;
      send_byte(it);
    end
  endtask

  initial begin
    logic [16:0] caps[8];
    int unsigned sent;
    php_pkg::in_item_t it;
    caps = '{php_pkg::CapacityReset, 17'd0, 17'd1, php_pkg::MaxCapacity, 17'h1FFFF,
             17'd3, 17'd0, 17'd2};
    caps[6] = 17'($urandom_range(17'h1FFFF));
    add_row(1, 8'h00, 32'd0, 1, php_pkg::KIND_INVALID);
    add_row(0, 8'hFF, 32'hFFFF_FFFF);
    add_row(1, 8'hFF, 32'd27, 1, php_pkg::KIND_INVALID);
    add_row(1, 8'h50, 32'hFFFF_FFFF);
    add_row(0, 8'h41, 0); add_row(0, 8'h31, 0); add_row(0, 8'h39, 0);
    add_row(0, 8'h01, 0); add_row(0, 8'h00, 0); add_row(0, 8'h44, 0);
    add_row(0, 8'h00, 0);
    add_row(0, 8'h85, 0, 1, php_pkg::KIND_NEW_SIZE);
    add_row(0, 8'h00, 0); add_row(0, 8'hFF, 0); add_row(0, 8'h00, 0);
    add_row(0, 8'hFF, 0);
    add_row(0, 8'h01, 0);
    add_row(0, 8'h83, 0, 1, php_pkg::KIND_OLD_SIZE);
    for (int i = 0; i < 6; i++) add_row(0, 8'h00, 0);
    add_row(0, 8'h80, 0, 1, php_pkg::KIND_ENTRY);
    add_row(0, 8'hFF, 0, 1, php_pkg::KIND_DONE);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) send_byte(dir_rows[i].it, dir_rows[i].chk, dir_rows[i].kind);
    for (int p = 0; p < 8; p++) begin
      drain(0);
      write_capacity(caps[p]);
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 77; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 77; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      sent = 0;
      while (sent < 80) begin
        if ($urandom_range(9) == 0) drain(0);
        if ($urandom_range(7) == 0) begin
          for (int j = 0; j < 4; j++) begin
            it.start_req = $urandom_range(7) == 0;
            it.data_byte = 8'($urandom);
            it.buffer_length = $urandom_range(1) ? $urandom : $urandom_range(40);
            send_byte(it);
          end
          sent += 4;
        end else begin
          send_header();
          sent += hdr_q.size();
        end
      end
    end
    drain(20);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
